// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers for the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, switched off while reset is held
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// same, with a message of its own
`define ASSERT_CLK_MSG(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

`endif

// File: src/rau_pkg.sv
// ----------------------------------------------------------------------------
// rau_pkg
// Types, codes and constants shared by the rational arithmetic unit.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int WIDTH        = 32;
    localparam int MAX_EXPONENT = 63;
    localparam int FIELD_W      = 32;
    localparam int MAG_W        = 64;
    localparam int SHIFT_W      = 6;
    localparam int EXP_W        = 6;
    localparam int DEN_W        = 31;

    localparam logic [MAG_W-1:0] HALF = 64'd1 << (WIDTH - 1);

    localparam logic [2:0] MODE_ADD = 3'd0;
    localparam logic [2:0] MODE_SUB = 3'd1;
    localparam logic [2:0] MODE_MUL = 3'd2;
    localparam logic [2:0] MODE_DIV = 3'd3;
    localparam logic [2:0] MODE_POW = 3'd4;
    localparam logic [2:0] MODE_RED = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZERO = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_MUL,
        DP_ADD,
        DP_LOAD_A,
        DP_GCD_START,
        DP_GCD_STEP,
        DP_DIV_START_N,
        DP_DIV_START_D,
        DP_DIV_STEP,
        DP_SIGN,
        DP_POW_INIT,
        DP_OUT_RES,
        DP_OUT_ERR
    } dp_op_t;

    typedef enum logic [2:0] {
        MS_AN_BD,
        MS_BN_AD,
        MS_AD_BD,
        MS_AN_BN,
        MS_N_AN,
        MS_D_AD
    } msel_t;

    typedef enum logic [1:0] {
        MD_N,
        MD_D,
        MD_T
    } mdst_t;

    typedef struct packed {
        dp_op_t op;
        msel_t  msel;
        mdst_t  mdst;
    } dp_cmd_t;

    typedef struct packed {
        logic       err;
        logic       gcd_done;
        logic       div_last;
        logic       k_zero;
        logic       fits;
        logic       out_free;
        logic [2:0] mode;
    } dp_stat_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_CHECK,
        S_ADD_T1,
        S_ADD_T2,
        S_ADD_SUM,
        S_MUL_N,
        S_MUL_D,
        S_DIV_N,
        S_DIV_D,
        S_LOAD_A,
        S_GCD_INIT,
        S_GCD_RUN,
        S_DIVN_INIT,
        S_DIVN_RUN,
        S_DIVD_INIT,
        S_DIVD_RUN,
        S_SIGN,
        S_POW_SETUP,
        S_POW_TEST,
        S_POW_MN,
        S_POW_MD,
        S_POW_CHK,
        S_FINISH,
        S_OUT_ERR
    } state_t;

endpackage

// File: src/rau_dp.sv
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared multiplier, signed adder, binary gcd,
// restoring divider and the result register.
// ----------------------------------------------------------------------------
module rau_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rau_pkg::dp_cmd_t              cmd,
    output rau_pkg::dp_stat_t             stat,
    input  logic [2:0]                    mode,
    input  logic signed [31:0]            a_num,
    input  logic signed [31:0]            a_den,
    input  logic signed [31:0]            b_num,
    input  logic signed [31:0]            b_den,
    input  logic [5:0]                    exponent,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            res_num,
    output logic [30:0]                   res_den,
    output logic [1:0]                    status
);
    import rau_pkg::*;

    logic [2:0]         mode_reg;
    logic [EXP_W-1:0]   k_reg;
    logic [FIELD_W-1:0] an_m_reg, ad_m_reg, bn_m_reg, bd_m_reg;
    logic               an_s_reg, ad_s_reg, bn_s_reg, bd_s_reg;
    logic [MAG_W-1:0]   n_m_reg, d_m_reg, t_m_reg;
    logic               n_s_reg, d_s_reg, t_s_reg;
    logic [MAG_W-1:0]   gu_reg, gv_reg;
    logic [SHIFT_W-1:0] gk_reg;
    logic [MAG_W-1:0]   dq_reg, drem_reg, ddiv_reg;
    logic [SHIFT_W-1:0] dcnt_reg;
    logic               dtgt_d_reg;
    logic               out_valid_reg;
    logic [FIELD_W-1:0] res_num_reg;
    logic [DEN_W-1:0]   res_den_reg;
    logic [1:0]         status_reg;

    logic [FIELD_W-1:0] mul_x, mul_y;
    logic               mul_sx, mul_sy;
    logic [MAG_W-1:0]   mul_prod;
    logic [MAG_W-1:0]   sum_m;
    logic               sum_s;
    logic [MAG_W:0]     div_sh;
    logic               div_ge;
    logic [MAG_W-1:0]   div_q_next;
    logic [MAG_W-1:0]   div_r_next;
    logic               fits;
    logic [7:0]         exp_clamp;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_x  = an_m_reg;
        mul_sx = an_s_reg;
        mul_y  = bd_m_reg;
        mul_sy = bd_s_reg;
        unique case (cmd.msel)
            MS_AN_BD:
            begin
                mul_x = an_m_reg; mul_sx = an_s_reg;
                mul_y = bd_m_reg; mul_sy = bd_s_reg;
            end
            MS_BN_AD:
            begin
                mul_x = bn_m_reg; mul_sx = bn_s_reg;
                mul_y = ad_m_reg; mul_sy = ad_s_reg;
            end
            MS_AD_BD:
            begin
                mul_x = ad_m_reg; mul_sx = ad_s_reg;
                mul_y = bd_m_reg; mul_sy = bd_s_reg;
            end
            MS_AN_BN:
            begin
                mul_x = an_m_reg; mul_sx = an_s_reg;
                mul_y = bn_m_reg; mul_sy = bn_s_reg;
            end
            MS_N_AN:
            begin
                mul_x = n_m_reg[FIELD_W-1:0]; mul_sx = n_s_reg;
                mul_y = an_m_reg;             mul_sy = an_s_reg;
            end
            MS_D_AD:
            begin
                mul_x = d_m_reg[FIELD_W-1:0]; mul_sx = d_s_reg;
                mul_y = ad_m_reg;             mul_sy = ad_s_reg;
            end
            default:
            begin
                mul_x = an_m_reg; mul_sx = an_s_reg;
                mul_y = bd_m_reg; mul_sy = bd_s_reg;
            end
        endcase
    end

    assign mul_prod = MAG_W'(mul_x) * MAG_W'(mul_y);

    // sign and magnitude add of n and t, a zero product may carry either sign
    always_comb
    begin
        if (n_s_reg == t_s_reg)
        begin
            sum_m = n_m_reg + t_m_reg;
            sum_s = n_s_reg;
        end
        else if (n_m_reg >= t_m_reg)
        begin
            sum_m = n_m_reg - t_m_reg;
            sum_s = n_s_reg;
        end
        else
        begin
            sum_m = t_m_reg - n_m_reg;
            sum_s = t_s_reg;
        end
        if (sum_m == '0)
            sum_s = 1'b0;
    end

    // one restoring divider step
    assign div_sh     = {drem_reg, dq_reg[MAG_W-1]};
    assign div_ge     = div_sh >= {1'b0, ddiv_reg};
    assign div_r_next = div_ge ? MAG_W'(div_sh - {1'b0, ddiv_reg}) : div_sh[MAG_W-1:0];
    assign div_q_next = {dq_reg[MAG_W-2:0], div_ge};

    always_comb
    begin
        if (d_m_reg == '0 || d_m_reg > HALF - 64'd1)
            fits = 1'b0;
        else if (n_s_reg)
            fits = n_m_reg <= HALF;
        else
            fits = n_m_reg <= HALF - 64'd1;
    end

    assign exp_clamp = (8'(exponent) > 8'(MAX_EXPONENT)) ? 8'(MAX_EXPONENT) : 8'(exponent);

    always_comb
    begin
        stat.err      = (mode_reg > MODE_RED) || (ad_m_reg == '0)
                        || ((mode_reg <= MODE_DIV) && (bd_m_reg == '0))
                        || ((mode_reg == MODE_DIV) && (bn_m_reg == '0));
        stat.gcd_done = gu_reg == '0;
        stat.div_last = dcnt_reg == SHIFT_W'(MAG_W - 1);
        stat.k_zero   = k_reg == '0;
        stat.fits     = fits;
        stat.out_free = !(out_valid_reg && out_stall);
        stat.mode     = mode_reg;
    end

    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            DP_LOAD:
            begin
                mode_reg <= mode;
                k_reg    <= EXP_W'(exp_clamp);
                an_s_reg <= a_num[31];
                an_m_reg <= a_num[31] ? (~a_num + 32'd1) : a_num;
                ad_s_reg <= a_den[31];
                ad_m_reg <= a_den[31] ? (~a_den + 32'd1) : a_den;
                bn_s_reg <= b_num[31] ^ ((mode == MODE_SUB) && (b_num != '0));
                bn_m_reg <= b_num[31] ? (~b_num + 32'd1) : b_num;
                bd_s_reg <= b_den[31];
                bd_m_reg <= b_den[31] ? (~b_den + 32'd1) : b_den;
            end
            DP_MUL:
            begin
                unique case (cmd.mdst)
                    MD_N:    begin n_m_reg <= mul_prod; n_s_reg <= mul_sx ^ mul_sy; end
                    MD_D:    begin d_m_reg <= mul_prod; d_s_reg <= mul_sx ^ mul_sy; end
                    MD_T:    begin t_m_reg <= mul_prod; t_s_reg <= mul_sx ^ mul_sy; end
                    default: begin t_m_reg <= mul_prod; t_s_reg <= mul_sx ^ mul_sy; end
                endcase
                if (cmd.msel == MS_N_AN)
                    k_reg <= k_reg - EXP_W'(1);
            end
            DP_ADD:
            begin
                n_m_reg <= sum_m;
                n_s_reg <= sum_s;
            end
            DP_LOAD_A:
            begin
                n_m_reg <= MAG_W'(an_m_reg);
                n_s_reg <= an_s_reg;
                d_m_reg <= MAG_W'(ad_m_reg);
                d_s_reg <= ad_s_reg;
            end
            DP_GCD_START:
            begin
                gu_reg <= n_m_reg;
                gv_reg <= d_m_reg;
                gk_reg <= '0;
            end
            DP_GCD_STEP:
            begin
                priority if (!gu_reg[0] && !gv_reg[0])
                begin
                    gu_reg <= gu_reg >> 1;
                    gv_reg <= gv_reg >> 1;
                    gk_reg <= gk_reg + SHIFT_W'(1);
                end
                else if (!gu_reg[0])
                    gu_reg <= gu_reg >> 1;
                else if (!gv_reg[0])
                    gv_reg <= gv_reg >> 1;
                else if (gu_reg >= gv_reg)
                    gu_reg <= gu_reg - gv_reg;
                else
                    gv_reg <= gv_reg - gu_reg;
            end
            DP_DIV_START_N, DP_DIV_START_D:
            begin
                dq_reg     <= (cmd.op == DP_DIV_START_D) ? d_m_reg : n_m_reg;
                dtgt_d_reg <= cmd.op == DP_DIV_START_D;
                drem_reg   <= '0;
                ddiv_reg   <= gv_reg << gk_reg;
                dcnt_reg   <= '0;
            end
            DP_DIV_STEP:
            begin
                dq_reg   <= div_q_next;
                drem_reg <= div_r_next;
                dcnt_reg <= dcnt_reg + SHIFT_W'(1);
                if (dcnt_reg == SHIFT_W'(MAG_W - 1))
                begin
                    if (dtgt_d_reg)
                        d_m_reg <= div_q_next;
                    else
                        n_m_reg <= div_q_next;
                end
            end
            DP_SIGN:
            begin
                n_s_reg <= (n_m_reg != '0) && (n_s_reg != d_s_reg);
                d_s_reg <= 1'b0;
            end
            DP_POW_INIT:
            begin
                // reduced a becomes the base, running power starts at one
                an_m_reg <= n_m_reg[FIELD_W-1:0];
                an_s_reg <= n_s_reg;
                ad_m_reg <= d_m_reg[FIELD_W-1:0];
                ad_s_reg <= 1'b0;
                n_m_reg  <= MAG_W'(1);
                n_s_reg  <= 1'b0;
                d_m_reg  <= MAG_W'(1);
                d_s_reg  <= 1'b0;
            end
            DP_OUT_RES:
            begin
                if (fits)
                begin
                    res_num_reg <= n_s_reg ? (~n_m_reg[FIELD_W-1:0] + 32'd1)
                                           : n_m_reg[FIELD_W-1:0];
                    res_den_reg <= d_m_reg[DEN_W-1:0];
                    status_reg  <= ST_OK;
                end
                else
                begin
                    res_num_reg <= '0;
                    res_den_reg <= '0;
                    status_reg  <= ST_OVF;
                end
            end
            DP_OUT_ERR:
            begin
                res_num_reg <= '0;
                res_den_reg <= '0;
                status_reg  <= ST_ZERO;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.op == DP_OUT_RES || cmd.op == DP_OUT_ERR)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid = out_valid_reg;
    assign res_num   = res_num_reg;
    assign res_den   = res_den_reg;
    assign status    = status_reg;

endmodule

// File: src/rau_ctrl.sv
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the datapath through multiply, reduce and power phases.
// ----------------------------------------------------------------------------
module rau_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  rau_pkg::dp_stat_t stat,
    output rau_pkg::dp_cmd_t  cmd
);
    import rau_pkg::*;

    state_t state_reg, state_next;
    logic   pow_reg, pow_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pow_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pow_reg   <= pow_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        pow_next   = pow_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_valid)
                begin
                    state_next = S_CHECK;
                    pow_next   = 1'b0;
                end
            S_CHECK:
                if (stat.err)
                    state_next = S_OUT_ERR;
                else if (stat.mode == MODE_ADD || stat.mode == MODE_SUB)
                    state_next = S_ADD_T1;
                else if (stat.mode == MODE_MUL)
                    state_next = S_MUL_N;
                else if (stat.mode == MODE_DIV)
                    state_next = S_DIV_N;
                else
                    state_next = S_LOAD_A;
            S_ADD_T1:    state_next = S_ADD_T2;
            S_ADD_T2:    state_next = S_ADD_SUM;
            S_ADD_SUM:   state_next = S_MUL_D;
            S_MUL_N:     state_next = S_MUL_D;
            S_MUL_D:     state_next = S_GCD_INIT;
            S_DIV_N:     state_next = S_DIV_D;
            S_DIV_D:     state_next = S_GCD_INIT;
            S_LOAD_A:    state_next = S_GCD_INIT;
            S_GCD_INIT:  state_next = S_GCD_RUN;
            S_GCD_RUN:
                if (stat.gcd_done)
                    state_next = S_DIVN_INIT;
            S_DIVN_INIT: state_next = S_DIVN_RUN;
            S_DIVN_RUN:
                if (stat.div_last)
                    state_next = S_DIVD_INIT;
            S_DIVD_INIT: state_next = S_DIVD_RUN;
            S_DIVD_RUN:
                if (stat.div_last)
                    state_next = S_SIGN;
            S_SIGN:
                if (stat.mode != MODE_POW)
                    state_next = S_FINISH;
                else if (pow_reg)
                    state_next = S_POW_CHK;
                else
                    state_next = S_POW_SETUP;
            S_POW_SETUP:
            begin
                state_next = S_POW_TEST;
                pow_next   = 1'b1;
            end
            S_POW_TEST:
                state_next = stat.k_zero ? S_FINISH : S_POW_MN;
            S_POW_MN:    state_next = S_POW_MD;
            S_POW_MD:    state_next = S_GCD_INIT;
            // a partial power that no longer fits ends the loop
            S_POW_CHK:
                state_next = stat.fits ? S_POW_TEST : S_FINISH;
            S_FINISH, S_OUT_ERR:
                if (stat.out_free)
                    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.op   = DP_NOP;
        cmd.msel = MS_AN_BD;
        cmd.mdst = MD_T;
        in_stall = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                    cmd.op = DP_LOAD;
            end
            S_ADD_T1:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_AN_BD; cmd.mdst = MD_N;
            end
            S_ADD_T2:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_BN_AD; cmd.mdst = MD_T;
            end
            S_ADD_SUM:   cmd.op = DP_ADD;
            S_MUL_N:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_AN_BN; cmd.mdst = MD_N;
            end
            S_MUL_D:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_AD_BD; cmd.mdst = MD_D;
            end
            S_DIV_N:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_AN_BD; cmd.mdst = MD_N;
            end
            S_DIV_D:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_BN_AD; cmd.mdst = MD_D;
            end
            S_LOAD_A:    cmd.op = DP_LOAD_A;
            S_GCD_INIT:  cmd.op = DP_GCD_START;
            S_GCD_RUN:
                if (!stat.gcd_done)
                    cmd.op = DP_GCD_STEP;
            S_DIVN_INIT: cmd.op = DP_DIV_START_N;
            S_DIVN_RUN:  cmd.op = DP_DIV_STEP;
            S_DIVD_INIT: cmd.op = DP_DIV_START_D;
            S_DIVD_RUN:  cmd.op = DP_DIV_STEP;
            S_SIGN:      cmd.op = DP_SIGN;
            S_POW_SETUP: cmd.op = DP_POW_INIT;
            S_POW_MN:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_N_AN; cmd.mdst = MD_N;
            end
            S_POW_MD:
            begin
                cmd.op = DP_MUL; cmd.msel = MS_D_AD; cmd.mdst = MD_D;
            end
            S_FINISH:
                if (stat.out_free)
                    cmd.op = DP_OUT_RES;
            S_OUT_ERR:
                if (stat.out_free)
                    cmd.op = DP_OUT_ERR;
            default:
            begin
            end
        endcase
    end

endmodule

// File: src/rational_arithmetic_unit.sv
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Add, subtract, multiply, divide, power and reduce of signed fractions,
// every result reduced by its gcd.
// ----------------------------------------------------------------------------
// One item is worked at a time and a new one is taken once the previous
// result sits in the output register. Add, subtract, multiply and divide
// use the shared 32x32 multiplier; these and reduce then run a binary gcd
// of one bit or one subtract per cycle and two restoring divisions by the
// gcd. Power repeats two multiplies, the gcd and both divisions once per
// exponent step after reducing the base, and stops early on overflow.
// Error items skip the arithmetic and go straight to the output.
module rational_arithmetic_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [2:0]          mode,
    input  logic signed [31:0]  a_num,
    input  logic signed [31:0]  a_den,
    input  logic signed [31:0]  b_num,
    input  logic signed [31:0]  b_den,
    input  logic [5:0]          exponent,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  res_num,
    output logic [30:0]         res_den,
    output logic [1:0]          status
);
    import rau_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    rau_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    rau_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .mode      (mode),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .exponent  (exponent),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .res_num   (res_num),
        .res_den   (res_den),
        .status    (status)
    );

endmodule

// File: src/rau_checker.sv
// ----------------------------------------------------------------------------
// rau_checker
// Port level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rau_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_stall,
    input logic                out_valid,
    input logic                out_stall,
    input logic signed [31:0]  res_num,
    input logic [30:0]         res_den,
    input logic [1:0]          status
);
    import rau_pkg::*;

    // a waiting result holds until its transfer
    `ASSERT_CLK(a_out_hold, clk, rst_n,
        out_valid && out_stall |=> out_valid && $stable(res_num)
        && $stable(res_den) && $stable(status))

    // one item at a time: busy straight after a transfer in
    `ASSERT_CLK(a_busy_after_in, clk, rst_n, in_valid && !in_stall |=> in_stall)

    `ASSERT_CLK_MSG(a_err_zero, clk, rst_n,
        out_valid && status != ST_OK |-> res_num == '0 && res_den == '0,
        "error result not cleared")

    `ASSERT_CLK_MSG(a_ok_den, clk, rst_n,
        out_valid && status == ST_OK |-> res_den != '0,
        "zero denominator on good result")

    `ASSERT_CLK_MSG(a_status_code, clk, rst_n,
        out_valid |-> status == ST_OK || status == ST_ZERO || status == ST_OVF,
        "bad status code")

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (.*);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rational arithmetic unit: a table of directed
// cases, then random fractions and modes, each result checked against its
// typed expectation or a behavioural model of the gcd-reduced arithmetic.
// ----------------------------------------------------------------------------
module tb;
    import rau_pkg::*;

    localparam logic [2:0] MODE_UNUSED6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED7 = 3'd7;
    localparam int N_RANDOM  = 1330;
    localparam int CYC_LIMIT = 20000000;

    typedef struct {
        bit          neg;
        logic [63:0] mag;
    } smag_t;

    typedef struct {
        logic signed [31:0] num;
        logic [30:0]        den;
        logic [1:0]         st;
    } frac_res_t;

    typedef struct {
        logic [2:0]  md;
        logic [31:0] an;
        logic [31:0] ad;
        logic [31:0] bn;
        logic [31:0] bd;
        logic [5:0]  k;
        bit          typed;
        frac_res_t   res;
    } dir_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [2:0]         mode = '0;
    logic signed [31:0] a_num = '0;
    logic signed [31:0] a_den = 32'sd1;
    logic signed [31:0] b_num = '0;
    logic signed [31:0] b_den = 32'sd1;
    logic [5:0]         exponent = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic [1:0]         status;

    // expectation travelling with a typed directed row
    bit        row_typed = 1'b0;
    frac_res_t row_res;

    frac_res_t expected_q[$];
    int        err_cnt = 0;
    int        cyc = 0;
    bit        long_hold = 1'b0;

    rational_arithmetic_unit u_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
        .exponent(exponent),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_num(res_num), .res_den(res_den), .status(status)
    );

    always #1 clk = ~clk;

    // ---------------- fraction model ----------------
    function automatic smag_t to_smag(logic [31:0] v);
        smag_t r;
        r.neg = v[31];
        r.mag = v[31] ? (64'h1_0000_0000 - {32'd0, v}) : {32'd0, v};
        return r;
    endfunction

    function automatic smag_t smul(smag_t x, smag_t y);
        smag_t r;
        r.mag = x.mag * y.mag;
        r.neg = (r.mag != 0) && (x.neg != y.neg);
        return r;
    endfunction

    function automatic smag_t sadd(smag_t x, smag_t y);
        smag_t r;
        if (x.neg == y.neg)
        begin
            r.mag = x.mag + y.mag;
            r.neg = x.neg;
        end
        else if (x.mag >= y.mag)
        begin
            r.mag = x.mag - y.mag;
            r.neg = x.neg;
        end
        else
        begin
            r.mag = y.mag - x.mag;
            r.neg = y.neg;
        end
        if (r.mag == 0) r.neg = 1'b0;
        return r;
    endfunction

    function automatic void lowest_terms(inout smag_t n, inout smag_t d);
        logic [63:0] x, y, t;
        x = n.mag;
        y = d.mag;
        while (y != 0)
        begin
            t = x % y;
            x = y;
            y = t;
        end
        if (x > 1)
        begin
            n.mag = n.mag / x;
            d.mag = d.mag / x;
        end
        n.neg = (n.mag != 0) && (n.neg != d.neg);
        d.neg = 1'b0;
    endfunction

    function automatic bit in_range(smag_t n, smag_t d);
        if (d.mag < 1 || d.mag > HALF - 1) return 1'b0;
        if (n.neg) return n.mag <= HALF;
        return n.mag <= HALF - 1;
    endfunction

    function automatic frac_res_t rational_calc(logic [2:0] md, logic [31:0] an_f,
            logic [31:0] ad_f, logic [31:0] bn_f, logic [31:0] bd_f, logic [5:0] k_f);
        smag_t an, ad, bn, bd, rn, rd;
        frac_res_t r;
        int k;
        logic [1:0] st;
        an = to_smag(an_f);
        ad = to_smag(ad_f);
        bn = to_smag(bn_f);
        bd = to_smag(bd_f);
        k = (k_f > MAX_EXPONENT) ? MAX_EXPONENT : k_f;
        st = ST_OK;
        rn = '{1'b0, 64'd0};
        rd = '{1'b0, 64'd1};
        if (md > MODE_RED || ad.mag == 0 || (md <= MODE_DIV && bd.mag == 0) ||
            (md == MODE_DIV && bn.mag == 0))
            st = ST_ZERO;
        else if (md == MODE_ADD || md == MODE_SUB)
        begin
            if (md == MODE_SUB) bn.neg = (bn.mag != 0) && !bn.neg;
            rn = sadd(smul(an, bd), smul(bn, ad));
            rd = smul(ad, bd);
            lowest_terms(rn, rd);
        end
        else if (md == MODE_MUL)
        begin
            rn = smul(an, bn);
            rd = smul(ad, bd);
            lowest_terms(rn, rd);
        end
        else if (md == MODE_DIV)
        begin
            rn = smul(an, bd);
            rd = smul(bn, ad);
            lowest_terms(rn, rd);
        end
        else if (md == MODE_POW)
        begin
            lowest_terms(an, ad);
            rn = '{1'b0, 64'd1};
            for (int i = 0; i < k; i++)
            begin
                rn = smul(rn, an);
                rd = smul(rd, ad);
                lowest_terms(rn, rd);
                if (!in_range(rn, rd)) break;
            end
        end
        else
        begin
            rn = an;
            rd = ad;
            lowest_terms(rn, rd);
        end
        if (st == ST_OK && !in_range(rn, rd)) st = ST_OVF;
        r.st = st;
        if (st != ST_OK)
        begin
            r.num = '0;
            r.den = '0;
        end
        else
        begin
            r.num = rn.neg ? (32'd0 - rn.mag[31:0]) : rn.mag[31:0];
            r.den = rd.mag[30:0];
        end
        return r;
    endfunction

    // ---------------- monitors ----------------
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            if (row_typed)
                expected_q.push_back(row_res);
            else
                expected_q.push_back(rational_calc(mode, a_num, a_den, b_num, b_den,
                                                   exponent));
        end
    end

    always @(posedge clk)
    begin
        frac_res_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_q.size() == 0)
            begin
                $display("%0t: result with nothing expected: %0d/%0d st %0d",
                         $time, res_num, res_den, status);
                err_cnt++;
            end
            else
            begin
                e = expected_q.pop_front();
                if (res_num !== e.num)
                begin
                    $display("%0t: res_num expected %0d actual %0d", $time, e.num, res_num);
                    err_cnt++;
                end
                if (res_den !== e.den)
                begin
                    $display("%0t: res_den expected %0d actual %0d", $time, e.den, res_den);
                    err_cnt++;
                end
                if (status !== e.st)
                begin
                    $display("%0t: status expected %0d actual %0d", $time, e.st, status);
                    err_cnt++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc > CYC_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------- receiver ----------------
    initial
    begin
        int r, n;
        bit v;
        bit held;
        held = 1'b0;
        @(posedge rst_n);
        forever
        begin
            r = $urandom_range(0, 99);
            if (long_hold && !held)
            begin
                held = 1'b1;
                v = 1'b1;
                n = 3000;
            end
            else if (r < 55)
            begin
                v = 1'b0;
                n = $urandom_range(1, 8);
            end
            else if (r < 90)
            begin
                v = 1'b1;
                n = $urandom_range(1, 3);
            end
            else if (r < 97)
            begin
                v = 1'b0;
                n = $urandom_range(20, 100);
            end
            else
            begin
                v = 1'b1;
                n = $urandom_range(20, 200);
            end
            @(posedge clk);
            out_stall <= v;
            repeat (n - 1) @(posedge clk);
        end
    end

    // ---------------- sender ----------------
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    function automatic logic [31:0] pick_operand();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return $urandom_range(0, 32) - 16;
        if (r < 7) return $urandom;
        if (r < 8)
        begin
            case ($urandom_range(0, 4))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'd1;
                3: return 32'hFFFF_FFFF;
                default: return 32'd0;
            endcase
        end
        return $urandom_range(0, 131072) - 65536;
    endfunction

    function automatic logic [31:0] pick_den();
        if ($urandom_range(0, 24) == 0) return 32'd0;
        return pick_operand();
    endfunction

    task automatic send_item(logic [2:0] md, logic [31:0] an, logic [31:0] ad,
                             logic [31:0] bn, logic [31:0] bd, logic [5:0] k,
                             bit typed, frac_res_t res);
        int gap;
        mode      <= md;
        a_num     <= an;
        a_den     <= ad;
        b_num     <= bn;
        b_den     <= bd;
        exponent  <= k;
        row_typed <= typed;
        row_res   <= res;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    dir_row_t dir_tab[$];

    function automatic frac_res_t fr(int n, int d, logic [1:0] s);
        frac_res_t r;
        r.num = n;
        r.den = 31'(d);
        r.st  = s;
        return r;
    endfunction

    function automatic dir_row_t row(logic [2:0] md, logic [31:0] an, logic [31:0] ad,
            logic [31:0] bn, logic [31:0] bd, logic [5:0] k, bit typed, frac_res_t res);
        dir_row_t d;
        d = '{md, an, ad, bn, bd, k, typed, res};
        return d;
    endfunction

    initial
    begin
        frac_res_t none;
        logic [2:0]  md;
        logic [31:0] an, ad;
        logic [5:0]  k;
        none = fr(0, 0, ST_OK);

        dir_tab.push_back(row(MODE_ADD, 1, 2, 1, 3, 0, 0, none));
        dir_tab.push_back(row(MODE_SUB, 32'h8000_0000, 1, 32'h7FFF_FFFF, 1, 0, 0, none));
        dir_tab.push_back(row(MODE_ADD, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                              32'h8000_0000, 0, 0, none));
        dir_tab.push_back(row(MODE_MUL, 32'h7FFF_FFFF, 1, 32'h7FFF_FFFF, 1, 0,
                              1, fr(0, 0, ST_OVF)));
        dir_tab.push_back(row(MODE_DIV, 3, 4, 32'hFFFF_FFFE, 5, 0, 0, none));
        dir_tab.push_back(row(MODE_DIV, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                              32'h8000_0000, 0, 0, none));
        // zero denominators, division by zero and unused modes
        dir_tab.push_back(row(MODE_ADD, 5, 0, 1, 1, 0, 1, fr(0, 0, ST_ZERO)));
        dir_tab.push_back(row(MODE_MUL, 5, 1, 1, 0, 0, 1, fr(0, 0, ST_ZERO)));
        dir_tab.push_back(row(MODE_DIV, 5, 1, 0, 7, 0, 1, fr(0, 0, ST_ZERO)));
        dir_tab.push_back(row(MODE_RED, 5, 0, 1, 1, 9, 1, fr(0, 0, ST_ZERO)));
        dir_tab.push_back(row(MODE_UNUSED6, 1, 1, 1, 1, 0, 1, fr(0, 0, ST_ZERO)));
        dir_tab.push_back(row(MODE_UNUSED7, 1, 1, 1, 1, 0, 1, fr(0, 0, ST_ZERO)));
        // power: zeroth power, ignored b, overflow, a unit base, negative bases
        dir_tab.push_back(row(MODE_POW, 0, 5, 0, 0, 0, 1, fr(1, 1, ST_OK)));
        dir_tab.push_back(row(MODE_POW, 2, 1, 3, 0, 3, 1, fr(8, 1, ST_OK)));
        dir_tab.push_back(row(MODE_POW, 2, 1, 0, 0, 63, 1, fr(0, 0, ST_OVF)));
        dir_tab.push_back(row(MODE_POW, 1, 32'hFFFF_FFFF, 0, 1, 63, 1, fr(-1, 1, ST_OK)));
        dir_tab.push_back(row(MODE_POW, 32'hFFFF_FFFE, 3, 0, 1, 7, 0, none));
        dir_tab.push_back(row(MODE_POW, 32'h8000_0000, 1, 0, 1, 1, 0, none));
        // reduce: zero, sign move, extremes
        dir_tab.push_back(row(MODE_RED, 0, 32'hFFFF_FFF9, 0, 1, 0, 1, fr(0, 1, ST_OK)));
        dir_tab.push_back(row(MODE_RED, 6, 32'hFFFF_FFFC, 0, 1, 0, 1, fr(-3, 2, ST_OK)));
        dir_tab.push_back(row(MODE_RED, 32'h8000_0000, 1, 0, 1, 0, 1,
                              fr(32'h8000_0000, 1, ST_OK)));
        dir_tab.push_back(row(MODE_RED, 1, 32'h8000_0000, 0, 1, 0, 1, fr(0, 0, ST_OVF)));
        dir_tab.push_back(row(MODE_RED, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF,
                              32'hFFFF_FFFF, 6'h3F, 1, fr(1, 1, ST_OK)));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_tab[i])
            send_item(dir_tab[i].md, dir_tab[i].an, dir_tab[i].ad, dir_tab[i].bn,
                      dir_tab[i].bd, dir_tab[i].k, dir_tab[i].typed, dir_tab[i].res);

        for (int i = 0; i < N_RANDOM; i++)
        begin
            // one long receiver hold-off while the sender keeps offering
            if (i == 100) long_hold <= 1'b1;
            md = ($urandom_range(0, 39) == 0) ? 3'($urandom_range(6, 7))
                                              : 3'($urandom_range(0, 5));
            an = pick_operand();
            ad = pick_den();
            k = 6'($urandom_range(0, 6));
            if (md == MODE_POW)
            begin
                if ($urandom_range(0, 19) == 0)
                    k = 6'($urandom_range(0, 63));
                else if ($urandom_range(0, 3) == 0)
                begin
                    // small bases so the power survives several steps
                    an = $urandom_range(0, 6) - 3;
                    ad = $urandom_range(1, 4);
                    k = 6'($urandom_range(0, 24));
                end
            end
            send_item(md, an, ad, pick_operand(), pick_den(), k, 1'b0, none);
        end
        in_valid <= 1'b0;

        while (expected_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (err_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
